FILE: design/c8fd_pkg.sv
// ----------------------------------------------------------------------------
// c8fd_pkg: shared types and constants for the CRC-8 frame deframer
// Phase and result kind codes, config register indexes, result struct and
// the byte-wide CRC-8 update (poly 0x07, MSB first).
// ----------------------------------------------------------------------------
package c8fd_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned LenW     = 16;
  localparam int unsigned TdataW   = 48;
  localparam int unsigned TuserW   = 2;

  localparam logic [7:0] CrcPoly = 8'h07;

  localparam logic [CfgIdxW-1:0] REG_LEAD_BYTE  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_EMIT_LIMIT = 2'd1;

  localparam logic [7:0]      LeadByteRst  = 8'hA5;
  localparam logic [LenW-1:0] EmitLimitRst = 16'hFFFF;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_OPCODE = 3'd1,
    PH_COMP   = 3'd2,
    PH_FLAG   = 3'd3,
    PH_SEQ    = 3'd4,
    PH_LEN_LO = 3'd5,
    PH_LEN_HI = 3'd6,
    PH_BODY   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_BAD_COMP = 2'd2,
    KIND_BAD_CRC  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e           kind;
    logic [7:0]      payload_byte;
    logic [7:0]      opcode;
    logic [7:0]      flag;
    logic [7:0]      sequence_num;
    logic [LenW-1:0] length;
    logic            end_of_frame;
  } result_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: design/c8fd_core.sv
// ----------------------------------------------------------------------------
// c8fd_core: frame phase tracking, header capture and CRC check
// Holds the per-frame state; decides the result of the current byte
// combinationally and advances state on each accepted beat.
// ----------------------------------------------------------------------------
module c8fd_core
  import c8fd_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            beat_i,
  input  logic [7:0]      byte_i,
  input  logic [7:0]      lead_byte_i,
  input  logic [LenW-1:0] emit_limit_i,
  output result_t         res_o,
  output logic            res_valid_o
);

  phase_e          phase_q, phase_d;
  logic [LenW-1:0] byte_count_q, byte_count_d;
  logic [7:0]      crc_q, crc_d;
  logic [7:0]      opcode_q, flag_q, seq_q;
  logic [LenW-1:0] held_len_q;

  logic [7:0] crc_next;
  logic       in_payload;
  logic       comp_ok;

  assign crc_next   = crc8_byte(crc_q, byte_i);
  assign in_payload = byte_count_q < held_len_q;
  assign comp_ok    = (~opcode_q) == byte_i;

  // next state
  always_comb begin
    phase_d      = phase_q;
    byte_count_d = byte_count_q;
    crc_d        = crc_q;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == lead_byte_i) begin
          phase_d = PH_OPCODE;
          crc_d   = crc8_byte(8'h00, byte_i);
        end
      end
      PH_OPCODE: begin
        phase_d = PH_COMP;
        crc_d   = crc_next;
      end
      PH_COMP: begin
        if (comp_ok) begin
          phase_d = PH_FLAG;
          crc_d   = crc_next;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_FLAG: begin
        phase_d = PH_SEQ;
        crc_d   = crc_next;
      end
      PH_SEQ: begin
        phase_d = PH_LEN_LO;
        crc_d   = crc_next;
      end
      PH_LEN_LO: begin
        phase_d = PH_LEN_HI;
        crc_d   = crc_next;
      end
      PH_LEN_HI: begin
        phase_d      = PH_BODY;
        crc_d        = crc_next;
        byte_count_d = '0;
      end
      PH_BODY: begin
        if (in_payload) begin
          crc_d        = crc_next;
          byte_count_d = byte_count_q + LenW'(1);
        end else begin
          phase_d      = PH_HUNT;
          byte_count_d = '0;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  // result for the current byte
  always_comb begin
    res_valid_o        = 1'b0;
    res_o.kind         = KIND_PAYLOAD;
    res_o.payload_byte = '0;
    res_o.opcode       = opcode_q;
    res_o.flag         = flag_q;
    res_o.sequence_num = seq_q;
    res_o.length       = held_len_q;
    res_o.end_of_frame = 1'b0;
    unique case (phase_q)
      PH_COMP: begin
        if (!comp_ok) begin
          res_valid_o        = 1'b1;
          res_o.kind         = KIND_BAD_COMP;
          res_o.flag         = '0;
          res_o.sequence_num = '0;
          res_o.length       = '0;
          res_o.end_of_frame = 1'b1;
        end
      end
      PH_BODY: begin
        if (in_payload) begin
          res_valid_o        = byte_count_q < emit_limit_i;
          res_o.payload_byte = byte_i;
        end else begin
          res_valid_o        = 1'b1;
          res_o.kind         = (crc_q == byte_i) ? KIND_GOOD : KIND_BAD_CRC;
          res_o.end_of_frame = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT;
      byte_count_q <= '0;
      crc_q        <= '0;
    end else if (beat_i) begin
      phase_q      <= phase_d;
      byte_count_q <= byte_count_d;
      crc_q        <= crc_d;
    end
  end

  // header capture, no reset needed
  always_ff @(posedge clk_i) begin
    if (beat_i) begin
      unique case (phase_q)
        PH_OPCODE: opcode_q <= byte_i;
        PH_FLAG:   flag_q   <= byte_i;
        PH_SEQ:    seq_q    <= byte_i;
        PH_LEN_LO: held_len_q <= {8'h00, byte_i};
        PH_LEN_HI: held_len_q <= {byte_i, held_len_q[7:0]};
        default: ;
      endcase
    end
  end

  a_hunt_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && phase_q == PH_HUNT && byte_i != lead_byte_i |=> phase_q == PH_HUNT)
    else $error("non-lead byte left hunt phase");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> byte_count_q <= held_len_q)
    else $error("payload count ran past header length");

  a_bad_comp_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && res_valid_o && res_o.kind == KIND_BAD_COMP |=> phase_q == PH_HUNT)
    else $error("bad complement did not resume hunting");

  a_end_rehunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && phase_q == PH_BODY && res_o.end_of_frame |=>
      phase_q == PH_HUNT && byte_count_q == '0)
    else $error("frame end did not reset phase and count");

endmodule

FILE: design/crc8_frame_deframer.sv
// ----------------------------------------------------------------------------
// crc8_frame_deframer: byte stream deframer for CRC-8 framed packets
// Hunts for the lead byte, checks the opcode complement and the trailing
// CRC-8, and forwards payload bytes with an end-of-frame status beat.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per beat. m_axis carries at most one
//   result per input beat: payload bytes (tuser = payload kind, tlast = 0)
//   up to the emit limit per frame, then one status beat with tlast = 1
//   (frame good, bad CRC) or a bad-complement status beat that ends the
//   frame early. Payload beats are provisional until the status beat.
//   Bytes dropped while hunting, header bytes and payload bytes past the
//   limit produce no output beat.
//   Throughput is one byte per cycle while the receiver is not stalling: the
//   byte-wide CRC update and the phase update sit between the frame state
//   registers and the output register, which shows each result on m_axis in the cycle after its input beat.
//   s_axis_tready stays high while the output register is empty or being
//   drained; a stalled receiver holds the result and backpressures input.
//   Reset returns to hunting with lead_byte = 0xA5 and emit limit = 65535.
//   The cfg port must be written only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module crc8_frame_deframer
  import c8fd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [7:0] payload_byte, [15:8] frame_opcode, [23:16] frame_flag,
  // [31:24] frame_sequence, [47:32] frame_length
  output logic [TdataW-1:0]   m_axis_tdata,
  output logic [TuserW-1:0]   m_axis_tuser,   // [1:0] result_kind
  output logic                m_axis_tlast    // end_of_frame
);

  logic [7:0]      lead_byte_q;
  logic [LenW-1:0] emit_limit_q;

  logic    beat;
  result_t res;
  logic    res_valid;
  result_t out_q;
  logic    out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_byte_q  <= LeadByteRst;
      emit_limit_q <= EmitLimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEAD_BYTE:  lead_byte_q  <= cfg_data_i[7:0];
        REG_EMIT_LIMIT: emit_limit_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign beat          = s_axis_tvalid && s_axis_tready;

  c8fd_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (beat),
    .byte_i       (s_axis_tdata),
    .lead_byte_i  (lead_byte_q),
    .emit_limit_i (emit_limit_q),
    .res_o        (res),
    .res_valid_o  (res_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (beat) begin
      out_valid_q <= res_valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.length, out_q.sequence_num, out_q.flag,
                          out_q.opcode, out_q.payload_byte};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.end_of_frame;

endmodule
